// ===== rtl/snms_pkg.sv =====
`timescale 1ns / 1ps
package snms_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int TRIG_DEPTH_DEF  = 1024;
  localparam int WET_BITS        = 17;
  localparam int MUL_W           = 34;

  localparam logic [31:0] SEED_LEFT   = 32'h9E37_79B9;
  localparam logic [31:0] SEED_RIGHT  = 32'h6C8E_9CF5;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [WET_BITS-1:0] WET_FULL = 17'd65536;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD_IN,
    OP_START,
    OP_PHASE,
    OP_RD0,
    OP_RD1,
    OP_IMUL,
    OP_IADD,
    OP_SHAPE,
    OP_NW,
    OP_W,
    OP_NS,
    OP_S,
    OP_OUTY,
    OP_MIX1,
    OP_MIX2,
    OP_MIXOUT,
    OP_PUBLISH
  } op_t;

  typedef struct packed {
    op_t  op;
    logic ch;
  } cmd_t;

  function automatic logic [31:0] xorshift32(input logic [31:0] s);
    logic [31:0] a;
    logic [31:0] b;
    a = s ^ (s << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

endpackage

// ===== rtl/stereo_noise_modulated_saturator_top.sv =====
`timescale 1ns / 1ps
// Channel  Handshake          Payload
// in_      tvalid/tready      tdata = {right, left}, tlast = frame last
// out_     tvalid/tready      tdata = {right, left}, tlast = copy of frame last
// cfg_     valid/ready        data = wet gain, Q1.16
//
// One stereo frame is processed before the next is accepted: it takes
// 20 steps per channel through the single shared multiplier and the
// registered trig ROM port, plus one accept and one publish step; the
// result is loaded into the output register at the publish step.
// rst_n is synchronous, active low; it restores seeds, history and gain.
// A held result does not stop a new frame from being accepted; the block
// stalls only at the publish step while the previous result is unread.
module stereo_noise_modulated_saturator_top #(
  parameter int SAMPLE_BITS      = snms_pkg::SAMPLE_BITS_DEF,
  parameter int TRIG_TABLE_DEPTH = snms_pkg::TRIG_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] in_tdata,  // sample_left, sample_right
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] out_tdata, // out_left, out_right
  output logic                              out_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [snms_pkg::WET_BITS-1:0]     cfg_data
);

  localparam int DW = ((2 * SAMPLE_BITS + 7) / 8) * 8;

  snms_pkg::cmd_t              cmd;
  logic signed [SAMPLE_BITS-1:0] res_left, res_right;

  assign cfg_ready = 1'b1;

  snms_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  snms_datapath #(
    .SAMPLE_BITS      (SAMPLE_BITS),
    .TRIG_TABLE_DEPTH (TRIG_TABLE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_left   (in_tdata[SAMPLE_BITS-1:0]),
    .in_right  (in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .in_last   (in_tlast),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_wdata (cfg_data),
    .out_left  (res_left),
    .out_right (res_right),
    .out_last  (out_tlast)
  );

  assign out_tdata = DW'({res_right, res_left});

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while a frame is in progress");

  a_publish_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == snms_pkg::OP_PUBLISH) |=> out_tvalid)
    else $error("published result not presented");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> (cmd.op != snms_pkg::OP_PUBLISH))
    else $error("pending result overwritten");
`endif

endmodule

// ===== rtl/snms_ctrl.sv =====
`timescale 1ns / 1ps
module snms_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output snms_pkg::cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_START, S_PHASE, S_RD0, S_RD1, S_IMUL, S_IADD, S_SHAPE,
    S_NW, S_W, S_NS, S_S, S_OUTY, S_MIX1, S_MIX2, S_MIXOUT, S_DONE
  } state_t;

  state_t state_r;
  logic   ch_r;
  logic   pass_r;
  logic   out_valid_r;
  logic   slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd.ch = ch_r;
    case (state_r)
      S_IDLE:   cmd.op = in_tvalid ? snms_pkg::OP_LOAD_IN : snms_pkg::OP_NONE;
      S_START:  cmd.op = snms_pkg::OP_START;
      S_PHASE:  cmd.op = snms_pkg::OP_PHASE;
      S_RD0:    cmd.op = snms_pkg::OP_RD0;
      S_RD1:    cmd.op = snms_pkg::OP_RD1;
      S_IMUL:   cmd.op = snms_pkg::OP_IMUL;
      S_IADD:   cmd.op = snms_pkg::OP_IADD;
      S_SHAPE:  cmd.op = snms_pkg::OP_SHAPE;
      S_NW:     cmd.op = snms_pkg::OP_NW;
      S_W:      cmd.op = snms_pkg::OP_W;
      S_NS:     cmd.op = snms_pkg::OP_NS;
      S_S:      cmd.op = snms_pkg::OP_S;
      S_OUTY:   cmd.op = snms_pkg::OP_OUTY;
      S_MIX1:   cmd.op = snms_pkg::OP_MIX1;
      S_MIX2:   cmd.op = snms_pkg::OP_MIX2;
      S_MIXOUT: cmd.op = snms_pkg::OP_MIXOUT;
      S_DONE:   cmd.op = slot_free ? snms_pkg::OP_PUBLISH : snms_pkg::OP_NONE;
      default:  cmd.op = snms_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ch_r        <= 1'b0;
      pass_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_DONE && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          ch_r <= 1'b0;
          if (in_tvalid) begin
            state_r <= S_START;
          end
        end
        S_START: begin
          pass_r  <= 1'b0;
          state_r <= S_PHASE;
        end
        S_PHASE:  state_r <= S_RD0;
        S_RD0:    state_r <= S_RD1;
        S_RD1:    state_r <= S_IMUL;
        S_IMUL:   state_r <= S_IADD;
        S_IADD:   state_r <= pass_r ? S_OUTY : S_SHAPE;
        S_SHAPE:  state_r <= S_NW;
        S_NW:     state_r <= S_W;
        S_W:      state_r <= S_NS;
        S_NS:     state_r <= S_S;
        S_S: begin
          pass_r  <= 1'b1;
          state_r <= S_PHASE;
        end
        S_OUTY:   state_r <= S_MIX1;
        S_MIX1:   state_r <= S_MIX2;
        S_MIX2:   state_r <= S_MIXOUT;
        S_MIXOUT: begin
          if (ch_r) begin
            state_r <= S_DONE;
          end else begin
            ch_r    <= 1'b1;
            state_r <= S_START;
          end
        end
        S_DONE: begin
          if (slot_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/snms_datapath.sv =====
`timescale 1ns / 1ps
module snms_datapath #(
  parameter int SAMPLE_BITS      = snms_pkg::SAMPLE_BITS_DEF,
  parameter int TRIG_TABLE_DEPTH = snms_pkg::TRIG_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  snms_pkg::cmd_t                      cmd,
  input  logic signed [SAMPLE_BITS-1:0]       in_left,
  input  logic signed [SAMPLE_BITS-1:0]       in_right,
  input  logic                                in_last,
  input  logic                                cfg_we,
  input  logic [snms_pkg::WET_BITS-1:0]       cfg_wdata,
  output logic signed [SAMPLE_BITS-1:0]       out_left,
  output logic signed [SAMPLE_BITS-1:0]       out_right,
  output logic                                out_last
);

  localparam int SB    = SAMPLE_BITS;
  localparam int FB    = SAMPLE_BITS - 1;
  localparam int AW    = $clog2(TRIG_TABLE_DEPTH + 1);
  localparam int MW    = snms_pkg::MUL_W;
  localparam int PW    = 2 * MW;
  localparam int SH_DN = (FB < 30) ? 30 - FB : 0;
  localparam int SH_UP = (FB > 30) ? FB - 30 : 0;
  localparam logic signed [63:0] RND = (64'sd1 <<< SH_DN) >>> 1;
  localparam logic signed [SB:0] ONE_S = {2'b01, {FB{1'b0}}};
  localparam logic [AW-1:0] LAST_IDX = AW'(TRIG_TABLE_DEPTH);

  typedef logic [30:0] rom_arr_t [0:TRIG_TABLE_DEPTH];

  function automatic rom_arr_t rom_init();
    rom_arr_t    t;
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] term;
    logic signed [63:0] acc;
    for (int i = 0; i <= TRIG_TABLE_DEPTH; i++) begin
      a    = snms_pkg::HALF_PI_Q30 * 64'(i) / TRIG_TABLE_DEPTH;
      a2   = (a * a) >> 30;
      term = a;
      acc  = $signed(a);
      for (int k = 1; k <= 8; k++) begin
        term = ((term * a2) >> 30) / 64'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) begin
          acc = acc - $signed(term);
        end else begin
          acc = acc + $signed(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      if (acc > 64'sd1073741824) begin
        acc = 64'sd1073741824;
      end
      t[i] = acc[30:0];
    end
    return t;
  endfunction

  localparam rom_arr_t TRIG_ROM = rom_init();

  function automatic logic signed [SB+1:0] q30_to_sample(input logic signed [33:0] v);
    logic signed [63:0] r;
    r = ((64'(v) + RND) >>> SH_DN) <<< SH_UP;
    return r[SB+1:0];
  endfunction

  function automatic logic signed [SB-1:0] sat_sample(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'(ONE_S) - 64'sd1;
    lo = -64'(ONE_S);
    if (v > hi) begin
      return hi[SB-1:0];
    end else if (v < lo) begin
      return lo[SB-1:0];
    end
    return v[SB-1:0];
  endfunction

  logic signed [SB-1:0] x_l_r, x_r_r, ps_l_r, ps_r_r, po_l_r, po_r_r;
  logic signed [SB-1:0] res_l_r, res_r_r, out_l_r, out_r_r, avg_r;
  logic                 last_r, out_last_r;
  logic [31:0]          ns_l_r, ns_r_r;
  logic [FB:0]          t_r, sh_r, pm_r;
  logic signed [PW-1:0] prod_r;
  logic signed [PW:0]   acc_r;
  logic [30:0]          y0_r, rom_q_r;
  logic signed [33:0]   sin_r;
  logic signed [SB:0]   shaped_r, w_r;
  logic signed [SB+1:0] sum_r;
  logic [snms_pkg::WET_BITS-1:0] wet_r;

  logic signed [SB-1:0] xc, ps_c, po_c;
  logic [31:0]          ns_c, ns_adv;
  logic signed [SB:0]   xe, xabs, pe, pabs;
  logic [FB:0]          t_start, pm_v, am_v, sh_v;
  logic signed [31:0]   nval;
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] mul_p, ish, nr_full;
  logic [AW-1:0]        idx, rom_addr;
  logic [FB-1:0]        fr;
  logic signed [31:0]   dlt;
  logic signed [33:0]   sin_v;
  logic signed [SB+1:0] shq, yq, ysg, sum_v, sabs;
  logic signed [SB:0]   shaped_v, nr;
  logic signed [SB-1:0] ys;
  logic signed [SB:0]   avg_sum;
  logic [snms_pkg::WET_BITS-1:0] wet_eff, dry_gain;
  logic signed [PW:0]   mix_full;

  assign xc   = cmd.ch ? x_r_r : x_l_r;
  assign ps_c = cmd.ch ? ps_r_r : ps_l_r;
  assign po_c = cmd.ch ? po_r_r : po_l_r;
  assign ns_c = cmd.ch ? ns_r_r : ns_l_r;
  assign ns_adv = snms_pkg::xorshift32(ns_c);
  assign nval = $signed({~ns_c[31], ns_c[30:0]});

  always_comb begin
    xe      = (SB+1)'(xc);
    xabs    = (xe < 0) ? -xe : xe;
    t_start = (xabs > ONE_S) ? '0 : (FB+1)'(ONE_S - xabs);
    pe      = (SB+1)'(ps_c);
    pabs    = (pe < 0) ? -pe : pe;
    pm_v    = pabs[FB:0];
  end

  assign idx = prod_r[FB +: AW];
  assign fr  = prod_r[FB-1:0];
  always_comb begin
    if (idx >= LAST_IDX) begin
      rom_addr = LAST_IDX;
    end else if (cmd.op == snms_pkg::OP_RD1) begin
      rom_addr = idx + AW'(1);
    end else begin
      rom_addr = idx;
    end
  end

  assign dlt   = $signed({1'b0, rom_q_r}) - $signed({1'b0, y0_r});
  assign ish   = prod_r >>> FB;
  assign sin_v = $signed({3'b000, y0_r}) + ish[33:0];

  always_comb begin
    shq = q30_to_sample(34'sd1073741824 - sin_r);
    if (shq < 0) begin
      sh_v = '0;
    end else if (shq > (SB+2)'(ONE_S)) begin
      sh_v = ONE_S[FB:0];
    end else begin
      sh_v = shq[FB:0];
    end
    shaped_v = (xc > 0) ? $signed({1'b0, sh_v}) : -$signed({1'b0, sh_v});
  end

  assign nr_full = (prod_r + (PW)'(64'sd1073741824)) >>> 31;
  assign nr      = nr_full[SB:0];

  always_comb begin
    sum_v = (SB+2)'(w_r) + (SB+2)'(nr);
    sabs  = (sum_v < 0) ? -sum_v : sum_v;
    am_v  = (sabs > (SB+2)'(ONE_S)) ? ONE_S[FB:0] : sabs[FB:0];
  end

  always_comb begin
    yq      = q30_to_sample(sin_r);
    ysg     = (sum_r > 0) ? yq : -yq;
    ys      = sat_sample(64'(ysg));
    avg_sum = ((SB+1)'(ys) + (SB+1)'(po_c)) >>> 1;
  end

  assign wet_eff  = (wet_r > snms_pkg::WET_FULL) ? snms_pkg::WET_FULL : wet_r;
  assign dry_gain = snms_pkg::WET_FULL - wet_eff;
  assign mix_full = (acc_r + (PW+1)'(32768)) >>> 16;

  always_comb begin
    case (cmd.op)
      snms_pkg::OP_PHASE: begin
        mul_a = MW'($signed({1'b0, t_r}));
        mul_b = MW'(TRIG_TABLE_DEPTH);
      end
      snms_pkg::OP_IMUL: begin
        mul_a = MW'(dlt);
        mul_b = MW'($signed({1'b0, fr}));
      end
      snms_pkg::OP_NW: begin
        mul_a = MW'(nval);
        mul_b = MW'($signed({1'b0, sh_r}));
      end
      snms_pkg::OP_NS: begin
        mul_a = MW'(nval);
        mul_b = MW'($signed({1'b0, pm_r}));
      end
      snms_pkg::OP_MIX1: begin
        mul_a = MW'(avg_r);
        mul_b = MW'($signed({1'b0, wet_eff}));
      end
      snms_pkg::OP_MIX2: begin
        mul_a = MW'(xc);
        mul_b = MW'($signed({1'b0, dry_gain}));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    rom_q_r <= TRIG_ROM[rom_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ns_l_r <= snms_pkg::SEED_LEFT;
      ns_r_r <= snms_pkg::SEED_RIGHT;
      ps_l_r <= '0;
      ps_r_r <= '0;
      po_l_r <= '0;
      po_r_r <= '0;
      wet_r  <= snms_pkg::WET_FULL;
    end else begin
      if (cfg_we) begin
        wet_r <= cfg_wdata;
      end
      case (cmd.op)
        snms_pkg::OP_LOAD_IN: begin
          x_l_r  <= in_left;
          x_r_r  <= in_right;
          last_r <= in_last;
        end
        snms_pkg::OP_START: t_r <= t_start;
        snms_pkg::OP_PHASE: prod_r <= mul_p;
        snms_pkg::OP_RD0: begin
        end
        snms_pkg::OP_RD1: y0_r <= rom_q_r;
        snms_pkg::OP_IMUL: prod_r <= mul_p;
        snms_pkg::OP_IADD: sin_r <= sin_v;
        snms_pkg::OP_SHAPE: begin
          sh_r     <= sh_v;
          shaped_r <= shaped_v;
          pm_r     <= pm_v;
        end
        snms_pkg::OP_NW: prod_r <= mul_p;
        snms_pkg::OP_W: begin
          w_r <= nr;
          if (cmd.ch) begin
            ns_r_r <= ns_adv;
          end else begin
            ns_l_r <= ns_adv;
          end
        end
        snms_pkg::OP_NS: prod_r <= mul_p;
        snms_pkg::OP_S: begin
          sum_r <= sum_v;
          t_r   <= am_v;
          if (cmd.ch) begin
            ps_r_r <= sat_sample(64'(shaped_r));
          end else begin
            ps_l_r <= sat_sample(64'(shaped_r));
          end
        end
        snms_pkg::OP_OUTY: begin
          avg_r <= avg_sum[SB-1:0];
          if (cmd.ch) begin
            po_r_r <= ys;
          end else begin
            po_l_r <= ys;
          end
        end
        snms_pkg::OP_MIX1: prod_r <= mul_p;
        snms_pkg::OP_MIX2: acc_r <= (PW+1)'(prod_r) + (PW+1)'(mul_p);
        snms_pkg::OP_MIXOUT: begin
          if (cmd.ch) begin
            res_r_r <= sat_sample(64'(mix_full));
            ns_r_r  <= ns_adv;
          end else begin
            res_l_r <= sat_sample(64'(mix_full));
            ns_l_r  <= ns_adv;
          end
        end
        snms_pkg::OP_PUBLISH: begin
          out_l_r    <= res_l_r;
          out_r_r    <= res_r_r;
          out_last_r <= last_r;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_left  = out_l_r;
  assign out_right = out_r_r;
  assign out_last  = out_last_r;

endmodule

// ===== test/tb_stereo_noise_modulated_saturator_top.sv =====
`timescale 1ns / 1ps
class saturator_scoreboard;
  localparam int TBL_DEPTH = 1024;
  localparam longint UNITY = 64'sd1 << 23;
  localparam longint UNITY_Q30 = 64'sd1 << 30;

  longint    sine_tbl[TBL_DEPTH+1];
  bit [31:0] lfsr[2];
  longint    last_shape[2];
  longint    last_y[2];
  longint    gain;
  logic [48:0] frames_due[$];
  int        errors;

  function new();
    longint unsigned a, a2, term;
    longint acc;
    for (int i = 0; i <= TBL_DEPTH; i++) begin
      a = 64'd1686629713 * i / TBL_DEPTH;
      a2 = (a * a) >> 30;
      term = a;
      acc = a;
      for (int k = 1; k <= 8; k++) begin
        term = ((term * a2) >> 30) / ((2 * k) * (2 * k + 1));
        if (k % 2) acc -= longint'(term);
        else acc += longint'(term);
      end
      if (acc < 0) acc = 0;
      if (acc > UNITY_Q30) acc = UNITY_Q30;
      sine_tbl[i] = acc;
    end
    errors = 0;
    reset_state();
  endfunction

  function void reset_state();
    gain = 65536;
    lfsr[0] = 32'h9E37_79B9;
    lfsr[1] = 32'h6C8E_9CF5;
    last_shape = '{0, 0};
    last_y = '{0, 0};
  endfunction

  function void set_gain(bit [16:0] g);
    gain = (g > 65536) ? 65536 : g;
  endfunction

  function bit [31:0] advance(bit [31:0] s);
    s ^= s << 13;
    s ^= s >> 17;
    s ^= s << 5;
    return s;
  endfunction

  function longint quarter_sine(longint t);
    longint p, idx, fr, d;
    p = t * TBL_DEPTH;
    idx = p >>> 23;
    fr = p & (UNITY - 1);
    if (idx >= TBL_DEPTH) return sine_tbl[TBL_DEPTH];
    d = sine_tbl[idx+1] - sine_tbl[idx];
    return sine_tbl[idx] + ((d * fr) >>> 23);
  endfunction

  function longint to_sample(longint v);
    return (v + 64) >>> 7;
  endfunction

  function longint clip(longint v);
    if (v > UNITY - 1) return UNITY - 1;
    if (v < -UNITY) return -UNITY;
    return v;
  endfunction

  function longint scale_noise(bit [31:0] s, longint m);
    longint n;
    n = longint'(s) - (64'sd1 << 31);
    return (n * m + (64'sd1 << 30)) >>> 31;
  endfunction

  function longint saturate_channel(longint x, int c);
    longint mag, sh, shaped, w, pm, sm, sum, am, y, avg;
    mag = x < 0 ? -x : x;
    if (mag > UNITY) mag = UNITY;
    sh = to_sample(UNITY_Q30 - quarter_sine(UNITY - mag));
    if (sh > UNITY) sh = UNITY;
    if (sh < 0) sh = 0;
    shaped = x > 0 ? sh : -sh;
    w = scale_noise(lfsr[c], sh);
    lfsr[c] = advance(lfsr[c]);
    pm = last_shape[c] < 0 ? -last_shape[c] : last_shape[c];
    sm = scale_noise(lfsr[c], pm);
    last_shape[c] = clip(shaped);
    sum = w + sm;
    am = sum < 0 ? -sum : sum;
    if (am > UNITY) am = UNITY;
    y = to_sample(quarter_sine(am));
    y = clip(sum > 0 ? y : -y);
    avg = (y + last_y[c]) >>> 1;
    last_y[c] = y;
    return clip((avg * gain + x * (65536 - gain) + 32768) >>> 16);
  endfunction

  function void note_frame(logic [47:0] data, logic last);
    longint l, r;
    logic [23:0] lo, ro;
    l = saturate_channel(longint'($signed(data[23:0])), 0);
    r = saturate_channel(longint'($signed(data[47:24])), 1);
    lfsr[0] = advance(lfsr[0]);
    lfsr[1] = advance(lfsr[1]);
    lo = l[23:0];
    ro = r[23:0];
    frames_due.push_back({last, ro, lo});
  endfunction

  function void check_frame(logic [47:0] data, logic last);
    logic [48:0] e;
    if (frames_due.size() == 0) begin
      $display("%0t unexpected frame: actual %h last %b", $time, data, last);
      errors++;
      return;
    end
    e = frames_due.pop_front();
    if (data[23:0] !== e[23:0]) begin
      $display("%0t left: expected %h actual %h", $time, e[23:0], data[23:0]);
      errors++;
    end
    if (data[47:24] !== e[47:24]) begin
      $display("%0t right: expected %h actual %h", $time, e[47:24], data[47:24]);
      errors++;
    end
    if (last !== e[48]) begin
      $display("%0t last: expected %b actual %b", $time, e[48], last);
      errors++;
    end
  endfunction
endclass

module tb_stereo_noise_modulated_saturator_top;
  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        in_tlast = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [47:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [16:0] cfg_data = '0;
  bit          steady = 0;

  saturator_scoreboard sb = new();

  stereo_noise_modulated_saturator_top DUT (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_frame(in_tdata, in_tlast);
    if (rst_n && out_tvalid && out_tready) sb.check_frame(out_tdata, out_tlast);
  end

  always @(posedge clk) out_tready <= steady || ($urandom_range(99) >= 17);

  task automatic send_frame(logic [23:0] l, logic [23:0] r, logic last);
    if (!steady && $urandom_range(99) < 17) begin
      in_tvalid <= 0;
      do @(posedge clk); while ($urandom_range(99) < 17);
    end
    in_tvalid <= 1;
    in_tdata <= {r, l};
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (sb.frames_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_gain(logic [16:0] g);
    drain();
    cfg_valid <= 1;
    cfg_data <= g;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    sb.set_gain(g);
  endtask

  function automatic logic [23:0] pick_sample();
    case ($urandom_range(4))
      0: return 24'($urandom());
      1: return 24'($urandom_range(32) - 16);
      2: return 24'(24'h7FFFFF - $urandom_range(4095));
      3: return 24'(24'h800000 + $urandom_range(4095));
      default: return 24'($signed(24'($urandom_range(16'hFFFF))) - 32768);
    endcase
  endfunction

  task automatic random_run(int n);
    for (int i = 0; i < n; i++)
      send_frame(pick_sample(), pick_sample(), $urandom_range(7) == 0);
  endtask

  localparam logic [23:0] EDGES[10] = '{24'h000000, 24'h7FFFFF, 24'h800000, 24'h800001,
    24'hFFFFFF, 24'h000001, 24'h400000, 24'hC00000, 24'h555555, 24'hAAAAAA};

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    for (int i = 0; i < 10; i++) send_frame(EDGES[i], EDGES[9-i], i[0]);
    for (int i = 0; i < 10; i++) send_frame(EDGES[(i*3)%10], EDGES[i], !i[0]);
    steady = 1;
    random_run(200);
    steady = 0;
    random_run(150);
    drain();
    random_run(150);
    write_gain(17'd0);
    random_run(200);
    write_gain(17'h1FFFF);
    random_run(200);
    write_gain(17'd32768);
    random_run(200);
    write_gain(17'd65537);
    random_run(150);
    write_gain(17'd1);
    random_run(150);
    write_gain(17'($urandom_range(65535)));
    random_run(200);
    drain();
    if (sb.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule
